// File: rtl/fsn_pkg.sv
// Shared constants, tables and helpers for the fractal simplex noise block.
// Holds the permutation table, gradient dot product and register codes.
// No dependencies.
package fsn_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PERM_SIZE = 256;
   localparam int PW = 26;          // corner offset width
   localparam int DW = 19;          // gradient dot width
   localparam int NW = 26;          // noise core output width
   localparam int NOISE_LAT = 13;   // noise core register stages

   localparam logic [14:0] F2K = 15'd23988;
   localparam logic [13:0] G2K = 14'd13849;
   localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
   localparam logic [30:0] Q12_ONE = 31'd4096;
   localparam logic [7:0] NOISE_SCALE = 8'd70;

   typedef enum logic [1:0] {
      CSR_OCTAVE_COUNT = 2'd0,
      CSR_PERSISTENCE  = 2'd1,
      CSR_LACUNARITY   = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic zero;
      logic sat;
   } div_flag_type;

   localparam logic [7:0] PERM_TABLE [PERM_SIZE] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
      8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
      8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
      8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
      8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
      8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
      8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
      8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
      8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
      8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
      8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
      8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
      8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
      8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
      8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [7:0] perm(input logic [7:0] idx);
      return PERM_TABLE[idx];
   endfunction

   // h mod 12 via reciprocal multiply, exact for 8-bit h
   function automatic logic [3:0] mod12(input logic [7:0] h);
      logic [15:0] p;
      logic [7:0] q;
      logic [7:0] r;
      p = 16'(h) * 16'd171;
      q = 8'(p >> 11);
      r = h - 8'(q * 8'd12);
      return r[3:0];
   endfunction

   function automatic logic signed [PW:0] grad_dot(input logic [3:0] g,
                                                   input logic signed [PW-1:0] px,
                                                   input logic signed [PW-1:0] py);
      logic signed [PW:0] ex;
      logic signed [PW:0] ey;
      logic signed [PW:0] d;
      ex = (PW+1)'(px);
      ey = (PW+1)'(py);
      case (g)
         4'd0:    d = ex + ey;
         4'd1:    d = ey - ex;
         4'd2:    d = ex - ey;
         4'd3:    d = -ex - ey;
         4'd4:    d = ex;
         4'd5:    d = -ex;
         4'd6:    d = ex;
         4'd7:    d = -ex;
         4'd8:    d = ey;
         4'd9:    d = -ey;
         4'd10:   d = ey;
         4'd11:   d = -ey;
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/fsn_noise.sv
// Pipelined 2D simplex noise core, Q16.16 in, signed Q10.16 out (26 bits), 13 stages.
// Depends on fsn_pkg (permutation table, gradients, constants).
module fsn_noise (
   input  logic                             clock,
   input  logic signed [31:0]               x_coord,
   input  logic signed [31:0]               y_coord,
   output logic signed [fsn_pkg::NW-1:0]    noise
);
   import fsn_pkg::*;

   localparam logic signed [PW-1:0] ONE_P = PW'(65536);
   localparam logic signed [PW-1:0] G2_P = PW'(G2K);
   localparam logic signed [PW-1:0] G2X2_P = PW'(2 * 13849);

   logic signed [32:0] sxy1_ff;
   logic signed [31:0] x1_ff, y1_ff;
   logic signed [48:0] sp2_ff;
   logic signed [31:0] x2_ff, y2_ff;
   logic signed [32:0] s3_in;
   logic signed [33:0] ax3_in, ay3_in;
   logic signed [17:0] i3_ff, j3_ff;
   logic [15:0] fx3_ff, fy3_ff;
   logic signed [32:0] s3_ff;
   logic signed [18:0] ij4_in;
   logic signed [33:0] t4_ff;
   logic [7:0] ii4_ff, pj0_4_ff, pj1_4_ff;
   logic [15:0] fx4_ff, fy4_ff;
   logic signed [32:0] s4_ff;
   logic signed [35:0] pxw5_in, pyw5_in;
   logic signed [PW-1:0] px5_ff, py5_ff;
   logic [7:0] ii5_ff, pj0_5_ff, pj1_5_ff;
   logic i1_6;
   logic signed [PW-1:0] px6_in [3];
   logic signed [PW-1:0] py6_in [3];
   logic [7:0] h6_in [3];
   logic signed [PW-1:0] px6_ff [3];
   logic signed [PW-1:0] py6_ff [3];
   logic [7:0] h6_ff [3];
   logic [3:0] g7_ff [3];
   logic signed [2*PW-1:0] sqx7_ff [3];
   logic signed [2*PW-1:0] sqy7_ff [3];
   logic signed [PW-1:0] px7_ff [3];
   logic signed [PW-1:0] py7_ff [3];
   logic [15:0] f8_in [3];
   logic signed [DW-1:0] d8_in [3];
   logic [15:0] f8_ff [3];
   logic signed [DW-1:0] d8_ff [3];
   logic [14:0] f2_9_ff [3];
   logic signed [DW-1:0] d9_ff [3];
   logic [12:0] f4_10_ff [3];
   logic signed [DW-1:0] d10_ff [3];
   logic signed [32:0] p11_ff [3];
   logic signed [18:0] sum12_in;
   logic signed [18:0] sum12_ff;
   logic signed [NW-1:0] n13_ff;

   always_comb begin
      s3_in  = 33'(sp2_ff >>> 16);
      ax3_in = 34'(x2_ff) + 34'(s3_in);
      ay3_in = 34'(y2_ff) + 34'(s3_in);
      ij4_in = 19'(i3_ff) + 19'(j3_ff);
      pxw5_in = $signed({20'd0, fx4_ff}) - 36'(s4_ff) + 36'(t4_ff);
      pyw5_in = $signed({20'd0, fy4_ff}) - 36'(s4_ff) + 36'(t4_ff);
   end

   always_comb begin
      i1_6 = px5_ff > py5_ff;
      px6_in[0] = px5_ff;
      py6_in[0] = py5_ff;
      px6_in[1] = px5_ff - (i1_6 ? ONE_P : '0) + G2_P;
      py6_in[1] = py5_ff - (i1_6 ? '0 : ONE_P) + G2_P;
      px6_in[2] = px5_ff - ONE_P + G2X2_P;
      py6_in[2] = py5_ff - ONE_P + G2X2_P;
      h6_in[0] = perm(ii5_ff + pj0_5_ff);
      h6_in[1] = perm(ii5_ff + {7'd0, i1_6} + (i1_6 ? pj0_5_ff : pj1_5_ff));
      h6_in[2] = perm(ii5_ff + 8'd1 + pj1_5_ff);
   end

   always_comb begin
      logic signed [2*PW:0] r2;
      logic [2*PW-16:0] r;
      logic signed [PW:0] dd;
      for (int c = 0; c < 3; c++) begin
         r2 = (2*PW+1)'(sqx7_ff[c]) + (2*PW+1)'(sqy7_ff[c]);
         r = (2*PW-15)'(r2 >>> 16);
         dd = grad_dot(g7_ff[c], px7_ff[c], py7_ff[c]);
         if (r < (2*PW-15)'(32768)) begin
            f8_in[c] = 16'(17'd32768 - {1'b0, r[15:0]});
            d8_in[c] = DW'(dd);
         end else begin
            f8_in[c] = '0;
            d8_in[c] = '0;
         end
      end
   end

   always_comb begin
      sum12_in = '0;
      for (int c = 0; c < 3; c++) begin
         sum12_in = sum12_in + 19'(p11_ff[c] >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      sxy1_ff  <= 33'(x_coord) + 33'(y_coord);
      x1_ff    <= x_coord;
      y1_ff    <= y_coord;
      sp2_ff   <= sxy1_ff * $signed({1'b0, F2K});
      x2_ff    <= x1_ff;
      y2_ff    <= y1_ff;
      i3_ff    <= 18'(ax3_in >>> 16);
      j3_ff    <= 18'(ay3_in >>> 16);
      fx3_ff   <= ax3_in[15:0];
      fy3_ff   <= ay3_in[15:0];
      s3_ff    <= s3_in;
      t4_ff    <= 34'(ij4_in) * 34'($signed({1'b0, G2K}));
      ii4_ff   <= i3_ff[7:0];
      pj0_4_ff <= perm(j3_ff[7:0]);
      pj1_4_ff <= perm(j3_ff[7:0] + 8'd1);
      fx4_ff   <= fx3_ff;
      fy4_ff   <= fy3_ff;
      s4_ff    <= s3_ff;
      px5_ff   <= pxw5_in[PW-1:0];
      py5_ff   <= pyw5_in[PW-1:0];
      ii5_ff   <= ii4_ff;
      pj0_5_ff <= pj0_4_ff;
      pj1_5_ff <= pj1_4_ff;
      for (int c = 0; c < 3; c++) begin
         px6_ff[c]   <= px6_in[c];
         py6_ff[c]   <= py6_in[c];
         h6_ff[c]    <= h6_in[c];
         g7_ff[c]    <= mod12(h6_ff[c]);
         sqx7_ff[c]  <= px6_ff[c] * px6_ff[c];
         sqy7_ff[c]  <= py6_ff[c] * py6_ff[c];
         px7_ff[c]   <= px6_ff[c];
         py7_ff[c]   <= py6_ff[c];
         f8_ff[c]    <= f8_in[c];
         d8_ff[c]    <= d8_in[c];
         f2_9_ff[c]  <= 15'((32'(f8_ff[c]) * 32'(f8_ff[c])) >> 16);
         d9_ff[c]    <= d8_ff[c];
         f4_10_ff[c] <= 13'((30'(f2_9_ff[c]) * 30'(f2_9_ff[c])) >> 16);
         d10_ff[c]   <= d9_ff[c];
         p11_ff[c]   <= 33'($signed({1'b0, f4_10_ff[c]})) * 33'(d10_ff[c]);
      end
      sum12_ff <= sum12_in;
      n13_ff   <= NW'(sum12_ff) * NW'($signed(NOISE_SCALE));
   end

   assign noise = n13_ff;

endmodule

// File: rtl/fsn_cell.sv
// One octave cell: steps frequency and amplitude, runs the noise core on the
// scaled point and adds the weighted result. Depends on fsn_pkg, fsn_noise.
module fsn_cell #(
   parameter int CNT_W = 4,
   parameter int SUM_W = 35,
   parameter int TOT_W = 60
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             persistence,
   input  logic [15:0]             lacunarity,
   input  logic                    in_valid,
   input  logic                    in_first,
   input  logic [CNT_W-1:0]        in_left,
   input  logic signed [31:0]      in_x,
   input  logic signed [31:0]      in_y,
   input  logic [30:0]             in_freq,
   input  logic [30:0]             in_amp,
   input  logic [SUM_W-1:0]        in_asum,
   input  logic signed [TOT_W-1:0] in_tot,
   output logic                    out_valid,
   output logic                    out_first,
   output logic [CNT_W-1:0]        out_left,
   output logic signed [31:0]      out_x,
   output logic signed [31:0]      out_y,
   output logic [30:0]             out_freq,
   output logic [30:0]             out_amp,
   output logic [SUM_W-1:0]        out_asum,
   output logic signed [TOT_W-1:0] out_tot
);
   import fsn_pkg::*;

   typedef struct packed {
      logic                    first;
      logic [CNT_W-1:0]        left;
      logic signed [31:0]      x;
      logic signed [31:0]      y;
      logic [30:0]             freq;
      logic [30:0]             amp;
      logic [SUM_W-1:0]        asum;
      logic signed [TOT_W-1:0] tot;
   } carry_type;

   carry_type car_in, car_a_ff, car_b_ff, car_b_in, car_c_ff, car_e_ff, car_f_ff, car_f_in;
   carry_type dly_ff [NOISE_LAT];
   logic v_a_ff, v_b_ff, v_c_ff, v_e_ff, v_f_ff;
   logic dly_v_ff [NOISE_LAT];
   logic [46:0] pf_a_ff, pa_a_ff;
   logic [34:0] fs_b, as_b;
   logic signed [63:0] xp_c_ff, yp_c_ff;
   logic signed [NW-1:0] noise;
   logic signed [NW+31:0] m_e_ff;

   assign car_in = '{first: in_first, left: in_left, x: in_x, y: in_y, freq: in_freq,
                     amp: in_amp, asum: in_asum, tot: in_tot};

   always_comb begin
      car_b_in = car_a_ff;
      fs_b = 35'(pf_a_ff >> 12);
      as_b = 35'(pa_a_ff >> 12);
      if (!car_a_ff.first) begin
         car_b_in.freq = (fs_b > 35'(SAT31)) ? SAT31 : fs_b[30:0];
         car_b_in.amp  = (as_b > 35'(SAT31)) ? SAT31 : as_b[30:0];
      end
      if (car_a_ff.left != '0) begin
         car_b_in.asum = car_a_ff.asum + SUM_W'(car_b_in.amp);
      end
   end

   always_comb begin
      car_f_in = car_e_ff;
      car_f_in.first = 1'b0;
      if (car_e_ff.left != '0) begin
         car_f_in.tot  = car_e_ff.tot + TOT_W'(m_e_ff);
         car_f_in.left = car_e_ff.left - CNT_W'(1);
      end
   end

   fsn_noise u_noise (
      .clock   (clock),
      .x_coord (xp_c_ff[43:12]),
      .y_coord (yp_c_ff[43:12]),
      .noise   (noise)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_e_ff <= 1'b0;
         v_f_ff <= 1'b0;
         for (int k = 0; k < NOISE_LAT; k++) dly_v_ff[k] <= 1'b0;
      end else begin
         v_a_ff <= in_valid;
         v_b_ff <= v_a_ff;
         v_c_ff <= v_b_ff;
         dly_v_ff[0] <= v_c_ff;
         for (int k = 1; k < NOISE_LAT; k++) dly_v_ff[k] <= dly_v_ff[k-1];
         v_e_ff <= dly_v_ff[NOISE_LAT-1];
         v_f_ff <= v_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      car_a_ff <= car_in;
      pf_a_ff  <= 47'(in_freq) * 47'(lacunarity);
      pa_a_ff  <= 47'(in_amp) * 47'(persistence);
      car_b_ff <= car_b_in;
      car_c_ff <= car_b_ff;
      xp_c_ff  <= 64'(car_b_ff.x) * $signed({33'd0, car_b_ff.freq});
      yp_c_ff  <= 64'(car_b_ff.y) * $signed({33'd0, car_b_ff.freq});
      dly_ff[0] <= car_c_ff;
      for (int k = 1; k < NOISE_LAT; k++) dly_ff[k] <= dly_ff[k-1];
      car_e_ff <= dly_ff[NOISE_LAT-1];
      m_e_ff   <= (NW+32)'(noise) * $signed({{(NW+1){1'b0}}, dly_ff[NOISE_LAT-1].amp});
      car_f_ff <= car_f_in;
   end

   assign out_valid = v_f_ff;
   assign out_first = car_f_ff.first;
   assign out_left  = car_f_ff.left;
   assign out_x     = car_f_ff.x;
   assign out_y     = car_f_ff.y;
   assign out_freq  = car_f_ff.freq;
   assign out_amp   = car_f_ff.amp;
   assign out_asum  = car_f_ff.asum;
   assign out_tot   = car_f_ff.tot;

endmodule

// File: rtl/fsn_div_cell.sv
// One restoring-division cell: resolves a single quotient bit per stage.
// Depends on fsn_pkg (div_flag_type).
module fsn_div_cell #(
   parameter int RW  = 50,
   parameter int DVW = 34,
   parameter int BIT = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  fsn_pkg::div_flag_type       in_flag,
   input  logic [RW-1:0]               in_rem,
   input  logic [DVW-1:0]              in_div,
   input  logic [15:0]                 in_quo,
   output logic                        out_valid,
   output fsn_pkg::div_flag_type       out_flag,
   output logic [RW-1:0]               out_rem,
   output logic [DVW-1:0]              out_div,
   output logic [15:0]                 out_quo
);
   import fsn_pkg::*;

   logic valid_ff;
   div_flag_type flag_ff;
   logic [RW-1:0] rem_ff, rem_in, sub;
   logic [DVW-1:0] div_ff;
   logic [15:0] quo_ff, quo_in;
   logic ge;

   always_comb begin
      sub = RW'(in_div) << BIT;
      ge = in_rem >= sub;
      rem_in = ge ? in_rem - sub : in_rem;
      quo_in = in_quo;
      quo_in[BIT] = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      flag_ff <= in_flag;
      rem_ff  <= rem_in;
      div_ff  <= in_div;
      quo_ff  <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_flag  = flag_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;

endmodule

// File: rtl/fractal_simplex_noise_2d.sv
// Top level of the fractal 2D simplex noise block: registers, octave chain
// and normalizing divider. Depends on fsn_pkg, fsn_cell, fsn_div_cell.
//
//   channel   ports                                   handshake
//   request   start, busy, req_x_coord, req_y_coord   start & !busy
//   response  rsp_valid, rsp_noise_value              one-cycle strobe
//   csr       csr_we, csr_index, csr_wdata            write on csr_we
//
// One beat accepted every cycle; busy is always low.
// Each octave cell is 18 stages (13 in its noise core), and the divider
// resolves one quotient bit per stage.
// Reset clears csr registers to their defaults and drops all valid bits.
// The response side cannot stall; results leave on the strobe cycle.
module fractal_simplex_noise_2d #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   output logic               rsp_valid,
   output logic [15:0]        rsp_noise_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import fsn_pkg::*;

   localparam int LG    = $clog2(MAX_OCTAVES);
   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W = 32 + LG;
   localparam int TOT_W = 57 + LG;
   localparam int NUM_W = TOT_W + 1;
   localparam int DVW   = SUM_W + 1;
   localparam int RW    = DVW + 16;
   localparam logic [4:0] MAX5 = 5'(MAX_OCTAVES);

   logic [3:0]  octave_count_ff;
   logic [15:0] persistence_ff, lacunarity_ff;

   logic               req_v_ff;
   logic signed [31:0] req_x_ff, req_y_ff;
   logic [CNT_W-1:0]   req_cnt_ff, cnt_in;

   logic                    ch_v     [MAX_OCTAVES+1];
   logic                    ch_first [MAX_OCTAVES+1];
   logic [CNT_W-1:0]        ch_left  [MAX_OCTAVES+1];
   logic signed [31:0]      ch_x     [MAX_OCTAVES+1];
   logic signed [31:0]      ch_y     [MAX_OCTAVES+1];
   logic [30:0]             ch_freq  [MAX_OCTAVES+1];
   logic [30:0]             ch_amp   [MAX_OCTAVES+1];
   logic [SUM_W-1:0]        ch_asum  [MAX_OCTAVES+1];
   logic signed [TOT_W-1:0] ch_tot   [MAX_OCTAVES+1];

   logic                    num_v_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [SUM_W-1:0]        num_asum_ff;
   logic [DVW-1:0]          dv_in;
   div_flag_type            prep_flag_in;

   logic                    dc_v    [17];
   div_flag_type            dc_flag [17];
   logic [RW-1:0]           dc_rem  [17];
   logic [DVW-1:0]          dc_div  [17];
   logic [15:0]             dc_quo  [17];

   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff, rsp_value_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= 4'd1;
         persistence_ff  <= 16'd2048;
         lacunarity_ff   <= 16'd8192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_wdata[3:0];
            CSR_PERSISTENCE:  persistence_ff  <= csr_wdata;
            CSR_LACUNARITY:   lacunarity_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (octave_count_ff == 4'd0) begin
         cnt_in = CNT_W'(1);
      end else if ({1'b0, octave_count_ff} > MAX5) begin
         cnt_in = CNT_W'(MAX_OCTAVES);
      end else begin
         cnt_in = CNT_W'(octave_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else begin
         req_v_ff <= start & ~busy;
      end
      req_x_ff   <= req_x_coord;
      req_y_ff   <= req_y_coord;
      req_cnt_ff <= cnt_in;
   end

   assign ch_v[0]     = req_v_ff;
   assign ch_first[0] = 1'b1;
   assign ch_left[0]  = req_cnt_ff;
   assign ch_x[0]     = req_x_ff;
   assign ch_y[0]     = req_y_ff;
   assign ch_freq[0]  = Q12_ONE;
   assign ch_amp[0]   = Q12_ONE;
   assign ch_asum[0]  = '0;
   assign ch_tot[0]   = '0;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      fsn_cell #(.CNT_W(CNT_W), .SUM_W(SUM_W), .TOT_W(TOT_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .persistence (persistence_ff),
         .lacunarity  (lacunarity_ff),
         .in_valid    (ch_v[k]),
         .in_first    (ch_first[k]),
         .in_left     (ch_left[k]),
         .in_x        (ch_x[k]),
         .in_y        (ch_y[k]),
         .in_freq     (ch_freq[k]),
         .in_amp      (ch_amp[k]),
         .in_asum     (ch_asum[k]),
         .in_tot      (ch_tot[k]),
         .out_valid   (ch_v[k+1]),
         .out_first   (ch_first[k+1]),
         .out_left    (ch_left[k+1]),
         .out_x       (ch_x[k+1]),
         .out_y       (ch_y[k+1]),
         .out_freq    (ch_freq[k+1]),
         .out_amp     (ch_amp[k+1]),
         .out_asum    (ch_asum[k+1]),
         .out_tot     (ch_tot[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_v_ff <= 1'b0;
      end else begin
         num_v_ff <= ch_v[MAX_OCTAVES];
      end
      num_ff      <= NUM_W'(ch_tot[MAX_OCTAVES]) + NUM_W'({ch_asum[MAX_OCTAVES], 16'd0});
      num_asum_ff <= ch_asum[MAX_OCTAVES];
   end

   always_comb begin
      dv_in = {num_asum_ff, 1'b0};
      prep_flag_in.zero = num_ff[NUM_W-1] | (num_ff == '0);
      prep_flag_in.sat  = ~prep_flag_in.zero &
                          (num_ff[NUM_W-2:0] >= (NUM_W-1)'({dv_in, 16'd0}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_v[0] <= 1'b0;
      end else begin
         dc_v[0] <= num_v_ff;
      end
      dc_flag[0] <= prep_flag_in;
      dc_rem[0]  <= num_ff[RW-1:0];
      dc_div[0]  <= dv_in;
      dc_quo[0]  <= '0;
   end

   for (genvar b = 0; b < 16; b++) begin : g_div
      fsn_div_cell #(.RW(RW), .DVW(DVW), .BIT(15 - b)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dc_v[b]),
         .in_flag   (dc_flag[b]),
         .in_rem    (dc_rem[b]),
         .in_div    (dc_div[b]),
         .in_quo    (dc_quo[b]),
         .out_valid (dc_v[b+1]),
         .out_flag  (dc_flag[b+1]),
         .out_rem   (dc_rem[b+1]),
         .out_div   (dc_div[b+1]),
         .out_quo   (dc_quo[b+1])
      );
   end

   always_comb begin
      if (dc_flag[16].zero) begin
         rsp_value_in = '0;
      end else if (dc_flag[16].sat) begin
         rsp_value_in = 16'hFFFF;
      end else begin
         rsp_value_in = dc_quo[16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dc_v[16];
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   a_asum_floor: assert property (@(posedge clock) disable iff (reset)
      ch_v[MAX_OCTAVES] |-> ch_asum[MAX_OCTAVES] >= SUM_W'(4096))
      else $error("amplitude sum below one at chain end");

   a_octaves_used: assert property (@(posedge clock) disable iff (reset)
      ch_v[MAX_OCTAVES] |-> ch_left[MAX_OCTAVES] == '0)
      else $error("octaves left over at chain end");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      dc_v[0] |-> !(dc_flag[0].zero && dc_flag[0].sat))
      else $error("divider zero and saturate both set");

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(dc_v[0], 17))
      else $error("response without a divider entry beat");

endmodule
